// File: hdl/ipdt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdt_pkg
// Types and constants shared by the pulse-distance IR transmitter core.
// ---------------------------------------------------------------------------
package ipdt_pkg;

   localparam int DUR_W  = 16;
   localparam int CNT_W  = 6;
   localparam int IDX_W  = 3;

   localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;

   // register indexes
   localparam logic [IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
   localparam logic [IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIT_MARK     = 3'd2;
   localparam logic [IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
   localparam logic [IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;
   localparam logic [IDX_W-1:0] REG_STOP         = 3'd5;

   // register reset values, in 1 us ticks
   localparam logic [DUR_W-1:0] RST_LEADER_MARK  = 16'd9000;
   localparam logic [DUR_W-1:0] RST_LEADER_SPACE = 16'd4500;
   localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd560;
   localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1680;
   localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd560;
   localparam logic [DUR_W-1:0] RST_STOP         = 16'd300;

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_SEND = 1'b1;

   typedef enum logic [6:0] {
      PH_IDLE        = 7'b0000001,
      PH_LEAD_MARK   = 7'b0000010,
      PH_LEAD_SPACE  = 7'b0000100,
      PH_BIT_MARK    = 7'b0001000,
      PH_BIT_SPACE   = 7'b0010000,
      PH_STOP_MARK   = 7'b0100000,
      PH_STOP_SPACE  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [7:0] cmd_value;
      logic [7:0] dev_addr;
   } req_type;

   typedef struct packed {
      logic carrier_on;
      logic busy_res;
      logic accepted;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0] leader_mark_us;
      logic [DUR_W-1:0] leader_space_us;
      logic [DUR_W-1:0] bit_mark_us;
      logic [DUR_W-1:0] one_space_us;
      logic [DUR_W-1:0] zero_space_us;
      logic [DUR_W-1:0] stop_us;
   } cfg_type;

   // a programmed zero lasts one tick
   function automatic logic [DUR_W-1:0] dur(input logic [DUR_W-1:0] v);
      dur = (v == '0) ? {{(DUR_W-1){1'b0}}, 1'b1} : v;
   endfunction

endpackage

// File: hdl/ipdt_csr.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdt_csr
// Duration registers; writes to unused indexes are dropped.
// ---------------------------------------------------------------------------
module ipdt_csr
   import ipdt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0] csr_wdata,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LEADER_MARK:  cfg_in.leader_mark_us  = csr_wdata;
            REG_LEADER_SPACE: cfg_in.leader_space_us = csr_wdata;
            REG_BIT_MARK:     cfg_in.bit_mark_us     = csr_wdata;
            REG_ONE_SPACE:    cfg_in.one_space_us    = csr_wdata;
            REG_ZERO_SPACE:   cfg_in.zero_space_us   = csr_wdata;
            REG_STOP:         cfg_in.stop_us         = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leader_mark_us  <= RST_LEADER_MARK;
         cfg_ff.leader_space_us <= RST_LEADER_SPACE;
         cfg_ff.bit_mark_us     <= RST_BIT_MARK;
         cfg_ff.one_space_us    <= RST_ONE_SPACE;
         cfg_ff.zero_space_us   <= RST_ZERO_SPACE;
         cfg_ff.stop_us         <= RST_STOP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/ipdt_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipdt_seq
// Frame sequencer: phase, tick countdown, data shifter and bit count.
// ---------------------------------------------------------------------------
module ipdt_seq
   import ipdt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   phase_type        phase_ff,  phase_in;
   logic [DUR_W-1:0] remain_ff, remain_in;
   logic [31:0]      shift_ff,  shift_in;
   logic [CNT_W-1:0] bits_ff,   bits_in;
   logic [CNT_W-1:0] bits_dec;

   always_comb begin
      phase_in  = phase_ff;
      remain_in = remain_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      bits_dec  = (bits_ff != '0) ? bits_ff - 1'b1 : bits_ff;
      result    = '0;
      if (item.func == FUNC_SEND) begin
         result.busy_res = 1'b1;
         if (phase_ff == PH_IDLE) begin
            shift_in = {item.cmd_value, ~item.cmd_value, item.dev_addr, ~item.dev_addr};
            bits_in  = FRAME_BITS;
            phase_in  = PH_LEAD_MARK;
            remain_in = dur(cfg.leader_mark_us);
            result.accepted = 1'b1;
         end
      end else if (phase_ff != PH_IDLE) begin
         result.busy_res   = 1'b1;
         result.carrier_on = (phase_ff == PH_LEAD_MARK) || (phase_ff == PH_BIT_MARK) ||
                             (phase_ff == PH_STOP_MARK);
         if (remain_ff > {{(DUR_W-1){1'b0}}, 1'b1}) begin
            remain_in = remain_ff - 1'b1;
         end else begin
            case (phase_ff)
               PH_LEAD_MARK: begin
                  phase_in  = PH_LEAD_SPACE;
                  remain_in = dur(cfg.leader_space_us);
               end
               PH_LEAD_SPACE: begin
                  phase_in  = PH_BIT_MARK;
                  remain_in = dur(cfg.bit_mark_us);
               end
               PH_BIT_MARK: begin
                  phase_in  = PH_BIT_SPACE;
                  remain_in = shift_ff[31] ? dur(cfg.one_space_us) : dur(cfg.zero_space_us);
               end
               PH_BIT_SPACE: begin
                  shift_in = {shift_ff[30:0], 1'b0};
                  bits_in  = bits_dec;
                  if (bits_dec == '0) begin
                     phase_in  = PH_STOP_MARK;
                     remain_in = dur(cfg.stop_us);
                  end else begin
                     phase_in  = PH_BIT_MARK;
                     remain_in = dur(cfg.bit_mark_us);
                  end
               end
               PH_STOP_MARK: begin
                  phase_in  = PH_STOP_SPACE;
                  remain_in = dur(cfg.stop_us);
               end
               default: begin
                  phase_in          = PH_IDLE;
                  remain_in         = '0;
                  result.frame_done = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         remain_ff <= '0;
         shift_ff  <= '0;
         bits_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
         shift_ff  <= shift_in;
         bits_ff   <= bits_in;
      end
   end

endmodule

// File: hdl/ir_pulse_distance_transmitter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ir_pulse_distance_transmitter_core
// Pulse-distance (NEC-style) IR frame transmitter, one beat per 1 us tick.
// ---------------------------------------------------------------------------
// Usage:
//   req_* : beats of kind tick (func=0) or send (func=1, cmd_value, dev_addr).
//           A send while idle loads a frame; while busy it is ignored.
//   rsp_* : exactly one result beat per request beat, in order, giving
//           carrier_on, busy_res, accepted and frame_done for that beat.
//   csr_* : six 16-bit duration registers, index 0..5; csr_ready is always
//           high, other indexes are dropped. Write only while idle.
// Throughput: one beat per cycle while rsp_stall is low. A taken beat passes
//   through the input register, then the result register, before rsp_*.
// Stall: when rsp_stall holds the result register full, the input register
//   holds too and req_stall rises; the sequencer state advances only when
//   a beat moves from the input register into the result register.
// Reset: synchronous; both stages empty, sequencer idle, registers at their
//   default NEC timings.
// ---------------------------------------------------------------------------
module ir_pulse_distance_transmitter_core
   import ipdt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [DUR_W-1:0] csr_wdata
);

   cfg_type cfg;
   rsp_type seq_result;

   logic    in_valid_ff;
   req_type in_item_ff;
   logic    out_valid_ff;
   rsp_type out_item_ff;
   logic    advance;
   logic    take;

   // input register moves on when the result slot is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   ipdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ipdt_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= seq_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   // frame end is a busy, dark tick
   a_done_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_done |-> rsp_payload.busy_res && !rsp_payload.carrier_on)
      else $error("frame_done with carrier or without busy");

   // a taken send reports busy and no carrier
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.accepted |-> rsp_payload.busy_res && !rsp_payload.carrier_on)
      else $error("accepted send not reported busy");

   a_carrier_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.carrier_on |-> rsp_payload.busy_res)
      else $error("carrier on while idle");

   // every beat leaving the input register lands in the result register
   a_advance_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result lost after advance");

endmodule
